@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL modules of the array list block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication in the same cycle, disabled while reset is held.
`define AST_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Check an implication in the following cycle, disabled while reset is held.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

@@ rtl/alir_pkg.sv @@
// Package with types, widths and codes of the array list block.
package alir_pkg;

    // Default list depth
    localparam int CAPACITY_DEF = 16;

    // Field widths fixed by the interface
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 16;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 3;
    localparam int ECNT_W   = 5;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DELETE  = 2'd1,
        CMD_REVERSE = 2'd2,
        CMD_READ    = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_OVERFLOW  = 3'd1,
        STAT_UNDERFLOW = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_BAD_POS   = 3'd4
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture a new transaction
        logic commit;  // apply the command and register its result
    } t_ctl;

endpackage

@@ rtl/alir_if.sv @@
// Command and result channel interfaces of the array list block.
interface alir_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [alir_pkg::CMD_W-1:0]     cmd;
    logic [alir_pkg::KEY_W-1:0]     entry_key;
    logic [alir_pkg::HANDLE_W-1:0]  record_handle;
    logic [alir_pkg::POS_W-1:0]     position;

    modport source (output valid, cmd, entry_key, record_handle, position, input ready);
    modport sink   (input valid, cmd, entry_key, record_handle, position, output ready);
endinterface

interface alir_res_if;
    logic                           valid;
    logic                           ready;
    logic [alir_pkg::STATUS_W-1:0]  status;
    logic [alir_pkg::ECNT_W-1:0]    entry_count;
    logic [alir_pkg::KEY_W-1:0]     read_key;
    logic [alir_pkg::HANDLE_W-1:0]  read_handle;

    modport source (output valid, status, entry_count, read_key, read_handle, input ready);
    modport sink   (input valid, status, entry_count, read_key, read_handle, output ready);
endinterface

@@ rtl/alir_ctrl.sv @@
// Controller state machine: sequences load and commit, owns the handshakes.
`include "assert_macros.svh"

module alir_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output alir_pkg::t_ctl o_ctl
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_load, w_commit;

    // Handshake decode
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_load     = i_in_valid && o_in_ready;
    assign w_commit   = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);

    // Next state and output slot
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_load) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_commit) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ctl.load    = w_load;
    assign o_ctl.commit  = w_commit;

    // An accepted transaction enters the execute state in the following cycle
    `AST_NEXT(a_load_exec, i_clk, i_rst_n, w_load, r_state == ST_EXEC)
    // A commit always leaves a result in the output slot
    `AST_NEXT(a_commit_out, i_clk, i_rst_n, w_commit, r_out_valid)

endmodule

@@ rtl/alir_dpath.sv @@
// Datapath: row of entry cells, order flag, count, and result registers.
`include "assert_macros.svh"

module alir_dpath #(
    parameter int CAPACITY = alir_pkg::CAPACITY_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  alir_pkg::t_ctl                 i_ctl,
    input  logic [alir_pkg::CMD_W-1:0]     i_cmd,
    input  logic [alir_pkg::KEY_W-1:0]     i_entry_key,
    input  logic [alir_pkg::HANDLE_W-1:0]  i_record_handle,
    input  logic [alir_pkg::POS_W-1:0]     i_position,
    output logic [alir_pkg::STATUS_W-1:0]  o_status,
    output logic [alir_pkg::ECNT_W-1:0]    o_entry_count,
    output logic [alir_pkg::KEY_W-1:0]     o_read_key,
    output logic [alir_pkg::HANDLE_W-1:0]  o_read_handle
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = (CNT_W > alir_pkg::POS_W) ? CNT_W : alir_pkg::POS_W;
    localparam logic [CAPACITY-1:0] ONES = {CAPACITY{1'b1}};

    // Entry cells and list state
    logic [alir_pkg::KEY_W-1:0]    r_key_cell [CAPACITY];
    logic [alir_pkg::KEY_W-1:0]    n_key_cell [CAPACITY];
    logic [alir_pkg::HANDLE_W-1:0] r_hdl_cell [CAPACITY];
    logic [alir_pkg::HANDLE_W-1:0] n_hdl_cell [CAPACITY];
    logic [CNT_W-1:0]              r_count, n_count;
    logic                          r_rev, n_rev;

    // Captured transaction and key match vector
    alir_pkg::t_cmd                r_cmd;
    logic [alir_pkg::KEY_W-1:0]    r_key;
    logic [alir_pkg::HANDLE_W-1:0] r_handle;
    logic [alir_pkg::POS_W-1:0]    r_pos;
    logic [CAPACITY-1:0]           r_match;

    // Result registers
    alir_pkg::t_status             r_status, n_status;
    logic [alir_pkg::ECNT_W-1:0]   r_ecnt;
    logic [alir_pkg::KEY_W-1:0]    r_rd_key, n_rd_key;
    logic [alir_pkg::HANDLE_W-1:0] r_rd_hdl, n_rd_hdl;

    logic [CMP_W-1:0]              w_pos, w_cnt, w_ins_at, w_rd_at, w_new_cnt;
    logic                          w_full, w_ins_pos_ok, w_rd_ok, w_any;
    logic [CAPACITY-1:0]           w_pre, w_above, w_del_shift;

    // Position arithmetic in a common width; a set order flag maps
    // logical position p to physical count-1-p
    assign w_pos        = CMP_W'(r_pos);
    assign w_cnt        = CMP_W'(r_count);
    assign w_full       = (w_cnt >= CMP_W'(CAPACITY));
    assign w_ins_pos_ok = (w_pos <= w_cnt);
    assign w_ins_at     = r_rev ? (w_cnt - w_pos) : w_pos;
    assign w_rd_ok      = (w_pos < w_cnt);
    assign w_rd_at      = r_rev ? (w_cnt - w_pos - CMP_W'(1)) : w_pos;
    assign w_any        = |r_match;

    // Gap closing mask: cells at and above the removed one take their upper
    // neighbor. Removed cell is the lowest match, or the highest when reversed.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_pre[i]       = |(r_match & (ONES >> (CAPACITY - 1 - i)));
            w_above[i]     = |(r_match & ~(ONES >> (CAPACITY - 1 - i)));
            w_del_shift[i] = r_rev ? !w_above[i] : w_pre[i];
        end
    end

    // Command execution
    always_comb begin
        n_key_cell = r_key_cell;
        n_hdl_cell = r_hdl_cell;
        n_count    = r_count;
        n_rev      = r_rev;
        n_status   = alir_pkg::STAT_OK;
        n_rd_key   = '0;
        n_rd_hdl   = '0;
        case (r_cmd)
            alir_pkg::CMD_INSERT: begin
                if (w_full) begin
                    n_status = alir_pkg::STAT_OVERFLOW;
                end else if (!w_ins_pos_ok) begin
                    n_status = alir_pkg::STAT_BAD_POS;
                end else begin
                    for (int i = 1; i < CAPACITY; i++) begin
                        if (CMP_W'(i) > w_ins_at) begin
                            n_key_cell[i] = r_key_cell[i-1];
                            n_hdl_cell[i] = r_hdl_cell[i-1];
                        end
                    end
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (CMP_W'(i) == w_ins_at) begin
                            n_key_cell[i] = r_key;
                            n_hdl_cell[i] = r_handle;
                        end
                    end
                    n_count = r_count + CNT_W'(1);
                end
            end
            alir_pkg::CMD_DELETE: begin
                if (r_count == '0) begin
                    n_status = alir_pkg::STAT_UNDERFLOW;
                end else if (!w_any) begin
                    n_status = alir_pkg::STAT_NOT_FOUND;
                end else begin
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (w_del_shift[i]) begin
                            n_key_cell[i] = r_key_cell[i+1];
                            n_hdl_cell[i] = r_hdl_cell[i+1];
                        end
                    end
                    n_count = r_count - CNT_W'(1);
                end
            end
            alir_pkg::CMD_REVERSE: begin
                n_rev = !r_rev;
            end
            alir_pkg::CMD_READ: begin
                if (w_rd_ok) begin
                    n_rd_key = r_key_cell[w_rd_at[IDX_W-1:0]];
                    n_rd_hdl = r_hdl_cell[w_rd_at[IDX_W-1:0]];
                end else begin
                    n_status = alir_pkg::STAT_BAD_POS;
                end
            end
            default: begin
                n_status = alir_pkg::STAT_OK;
            end
        endcase
    end

    assign w_new_cnt = CMP_W'(n_count);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rev   <= 1'b0;
        end else if (i_ctl.commit) begin
            r_count <= n_count;
            r_rev   <= n_rev;
        end
    end

    // Capture transaction and compare all live cells against its key
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= alir_pkg::t_cmd'(i_cmd);
            r_key    <= i_entry_key;
            r_handle <= i_record_handle;
            r_pos    <= i_position;
            for (int i = 0; i < CAPACITY; i++) begin
                r_match[i] <= (r_key_cell[i] == i_entry_key) &&
                              (CMP_W'(i) < CMP_W'(r_count));
            end
        end
    end

    // Cells and result payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_key_cell <= n_key_cell;
            r_hdl_cell <= n_hdl_cell;
            r_status   <= n_status;
            r_ecnt     <= w_new_cnt[alir_pkg::ECNT_W-1:0];
            r_rd_key   <= n_rd_key;
            r_rd_hdl   <= n_rd_hdl;
        end
    end

    assign o_status      = r_status;
    assign o_entry_count = r_ecnt;
    assign o_read_key    = r_rd_key;
    assign o_read_handle = r_rd_hdl;

    // Count stays within the list depth
    `AST_SAME(a_cnt_range, i_clk, i_rst_n, 1'b1, CMP_W'(r_count) <= CMP_W'(CAPACITY))
    // Count only moves on a commit
    `AST_NEXT(a_cnt_hold, i_clk, i_rst_n, !i_ctl.commit, $stable(r_count))

endmodule

@@ rtl/array_list_insert_delete_reverse.sv @@
// Top level of the ordered array list with insert, delete, reverse and read.
//
// Usage: commands arrive on i_cmd_ch (valid/ready); each command gives exactly
// one result transaction on o_res_ch with status, entry count and read data.
// A command is captured when accepted in the idle state, the live cells are
// compared against its key at capture, and the list is updated and the result
// registered on the commit in the execute state, which waits while the result
// slot is full; the next command is accepted only back in the idle state.
// The cell row shifts, searches and reads all entries in parallel; reverse
// toggles an order flag that remaps positions, so every command passes through
// the same load and commit steps regardless of CAPACITY or list length.
// A single result register parts the channels: the next command is taken
// while a result waits. If the receiver stalls, the following command waits
// in its execute cycle until the result slot frees, and input ready stays low.
// Reset (synchronous, active low) empties the list and clears the order flag
// and the result slot; the cell contents are not cleared and are only read
// below the entry count.
module array_list_insert_delete_reverse #(
    parameter int CAPACITY = alir_pkg::CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    alir_cmd_if.sink   i_cmd_ch,
    alir_res_if.source o_res_ch
);

    alir_pkg::t_ctl w_ctl;

    // Sequencing and handshakes
    alir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd_ch.valid),
        .o_in_ready  (i_cmd_ch.ready),
        .o_out_valid (o_res_ch.valid),
        .i_out_ready (o_res_ch.ready),
        .o_ctl       (w_ctl)
    );

    // List storage and command execution
    alir_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .i_cmd           (i_cmd_ch.cmd),
        .i_entry_key     (i_cmd_ch.entry_key),
        .i_record_handle (i_cmd_ch.record_handle),
        .i_position      (i_cmd_ch.position),
        .o_status        (o_res_ch.status),
        .o_entry_count   (o_res_ch.entry_count),
        .o_read_key      (o_res_ch.read_key),
        .o_read_handle   (o_res_ch.read_handle)
    );

endmodule
